### design/ray_sphere_closest_hit_assert.svh
// assertion macros for the closest-hit block
`ifndef RAY_SPHERE_CLOSEST_HIT_ASSERT_SVH
`define RAY_SPHERE_CLOSEST_HIT_ASSERT_SVH

`ifndef SYNTHESIS
`define RSCH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RSCH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSCH_ASSERT_NOW(lbl, ante, cons)
`define RSCH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/rsch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsch_pkg;

    localparam int MAX_SPHERE_COUNT = 16;
    localparam int FRAC_BITS        = 16;
    localparam int Q_DEPTH          = 2;
    localparam int Q_PTR_W          = $clog2(Q_DEPTH);
    localparam int Q_CNT_W          = $clog2(Q_DEPTH + 1);
    localparam int SQRT_STEPS       = 32;
    localparam int SQRT_CNT_W       = $clog2(SQRT_STEPS);

    typedef struct packed {
        logic signed [2:0][31:0] origin;
        logic signed [2:0][17:0] dir;
        logic signed [2:0][31:0] center;
        logic        [30:0]      radius;
        logic        [3:0]       index;
        logic                    last;
    } in_item_t;

    // one classified transaction between front and back
    typedef struct packed {
        logic                    cand;
        logic                    last;
        logic        [3:0]       index;
        logic signed [31:0]      b;
        logic        [63:0]      disc;
        logic signed [2:0][31:0] origin;
        logic signed [2:0][17:0] dir;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic                    hit;
        logic signed [31:0]      t;
        logic        [3:0]       index;
        logic signed [2:0][31:0] point;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### design/ray_sphere_closest_hit.sv
// Closest ray-sphere hit: each transaction pairs a ray with one sphere (Q16.16); the
// nearest hit of a group is reported once, on the transaction marked last_sphere.
// A four-stage front computes b, c and the discriminant and feeds a two-entry queue;
// the back runs a bit-serial square root in ST_SQRT. A sphere that misses is popped
// in ST_IDLE, a sphere that hits also passes ST_SQRT and ST_TMIN, and the last sphere
// of a group adds ST_PMUL and ST_PSUM, which waits for a free output register, before
// its result appears on the output register; the square root sets the sustained rate.
`timescale 1ns / 1ps
`default_nettype none
`include "ray_sphere_closest_hit_assert.svh"
module ray_sphere_closest_hit
    import rsch_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] origin_x,
    input  wire logic signed [31:0] origin_y,
    input  wire logic signed [31:0] origin_z,
    input  wire logic signed [17:0] dir_x,
    input  wire logic signed [17:0] dir_y,
    input  wire logic signed [17:0] dir_z,
    input  wire logic signed [31:0] center_x,
    input  wire logic signed [31:0] center_y,
    input  wire logic signed [31:0] center_z,
    input  wire logic        [30:0] sphere_radius,
    input  wire logic        [3:0]  sphere_index,
    input  wire logic               last_sphere,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    hit,
    output logic signed [31:0]      hit_t,
    output logic        [3:0]       hit_index,
    output logic signed [31:0]      point_x,
    output logic signed [31:0]      point_y,
    output logic signed [31:0]      point_z
);

    in_item_t  in_item;
    q_entry_t  q_wr;
    q_entry_t  q_rd;
    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    logic      out_valid;
    result_t   res;

    always_comb
    begin
        in_item.origin[0] = origin_x;
        in_item.origin[1] = origin_y;
        in_item.origin[2] = origin_z;
        in_item.dir[0]    = dir_x;
        in_item.dir[1]    = dir_y;
        in_item.dir[2]    = dir_z;
        in_item.center[0] = center_x;
        in_item.center[1] = center_y;
        in_item.center[2] = center_z;
        in_item.radius    = sphere_radius;
        in_item.index     = sphere_index;
        in_item.last      = last_sphere;
    end

    rsch_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push),
        .in_item  (in_item),
        .in_stall (full),
        .q_full   (q_status.full),
        .q_push   (q_push),
        .q_data   (q_wr)
    );

    rsch_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .status  (q_status)
    );

    rsch_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_rd),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_data  (res),
        .out_pop   (pop)
    );

    // result ports
    assign empty     = !out_valid;
    assign hit       = res.hit;
    assign hit_t     = res.t;
    assign hit_index = res.index;
    assign point_x   = res.point[0];
    assign point_y   = res.point[1];
    assign point_z   = res.point[2];

    // checks
    `RSCH_ASSERT_NOW(a_queue_state, 1'b1, !(q_status.full && q_status.empty))
    `RSCH_ASSERT_NOW(a_no_push_full, q_push, !q_status.full)
    `RSCH_ASSERT_NOW(a_miss_zero, !empty && !hit, hit_t == 32'sd0 && hit_index == 4'd0)
    `RSCH_ASSERT_NEXT(a_pop_only_filled, q_pop, $past(!q_status.empty))

endmodule
`default_nettype wire

### design/rsch_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rsch_front
    import rsch_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire in_item_t in_item,
    output logic          in_stall,
    input  wire logic     q_full,
    output logic          q_push,
    output q_entry_t      q_data
);

    logic adv;

    // stage 1: saturated offsets
    logic                    s1_valid_reg;
    logic signed [31:0]      s1_dl_reg [3];
    logic signed [31:0]      s1_dl_next [3];
    logic signed [2:0][31:0] s1_o_reg;
    logic signed [2:0][17:0] s1_d_reg;
    logic        [30:0]      s1_r_reg;
    logic        [3:0]       s1_idx_reg;
    logic                    s1_last_reg;

    // stage 2: products
    logic                    s2_valid_reg;
    logic signed [49:0]      s2_pd_reg [3];
    logic signed [49:0]      s2_pd_next [3];
    logic signed [63:0]      s2_pq_reg [3];
    logic signed [63:0]      s2_pq_next [3];
    logic        [61:0]      s2_rr_reg;
    logic        [61:0]      s2_rr_next;
    logic signed [2:0][31:0] s2_o_reg;
    logic signed [2:0][17:0] s2_d_reg;
    logic        [3:0]       s2_idx_reg;
    logic                    s2_last_reg;

    // stage 3: b and c
    logic                    s3_valid_reg;
    logic signed [31:0]      s3_b_reg;
    logic signed [31:0]      s3_b_next;
    logic signed [31:0]      s3_c_reg;
    logic signed [31:0]      s3_c_next;
    logic signed [2:0][31:0] s3_o_reg;
    logic signed [2:0][17:0] s3_d_reg;
    logic        [3:0]       s3_idx_reg;
    logic                    s3_last_reg;

    // stage 4: b squared and scaled c
    logic                    s4_valid_reg;
    logic signed [31:0]      s4_b_reg;
    logic signed [63:0]      s4_bb_reg;
    logic signed [63:0]      s4_bb_next;
    logic signed [63:0]      s4_c4_reg;
    logic signed [63:0]      s4_c4_next;
    logic signed [2:0][31:0] s4_o_reg;
    logic signed [2:0][17:0] s4_d_reg;
    logic        [3:0]       s4_idx_reg;
    logic                    s4_last_reg;

    logic signed [51:0] dot;
    logic        [63:0] sq;
    logic signed [63:0] disc;
    logic signed [32:0] diff [3];

    // whole pipe holds while the head cannot enter the queue
    assign adv      = !(s4_valid_reg && q_full);
    assign in_stall = !adv;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i]       = 33'($signed(in_item.origin[i])) - 33'($signed(in_item.center[i]));
            s1_dl_next[i] = sat32(64'(diff[i]));
            s2_pd_next[i] = $signed(s1_d_reg[i]) * s1_dl_reg[i];
            s2_pq_next[i] = s1_dl_reg[i] * s1_dl_reg[i];
        end
        s2_rr_next = 62'(s1_r_reg) * 62'(s1_r_reg);
    end

    always_comb
    begin
        dot = 52'(s2_pd_reg[0]) + 52'(s2_pd_reg[1]) + 52'(s2_pd_reg[2]);
        sq  = 64'(s2_pq_reg[0]) + 64'(s2_pq_reg[1]) + 64'(s2_pq_reg[2]);
        // floor(2*dot / 2^F) is floor(dot / 2^(F-1))
        s3_b_next = sat32(64'(dot) >>> (FRAC_BITS - 1));
        s3_c_next = sat32($signed(sq >> FRAC_BITS) - $signed(64'(s2_rr_reg >> FRAC_BITS)));
        s4_bb_next = 64'(s3_b_reg) * 64'(s3_b_reg);
        s4_c4_next = 64'(s3_c_reg) <<< (FRAC_BITS + 2);
    end

    // classify and hand over to the queue
    always_comb
    begin
        disc          = s4_bb_reg - s4_c4_reg;
        q_push        = s4_valid_reg && !q_full;
        q_data.cand   = (disc > 64'sd0) && (32'(s4_idx_reg) < MAX_SPHERE_COUNT);
        q_data.last   = s4_last_reg;
        q_data.index  = s4_idx_reg;
        q_data.b      = s4_b_reg;
        q_data.disc   = disc;
        q_data.origin = s4_o_reg;
        q_data.dir    = s4_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_dl_reg[i] <= s1_dl_next[i];
                s2_pd_reg[i] <= s2_pd_next[i];
                s2_pq_reg[i] <= s2_pq_next[i];
            end
            s1_o_reg    <= in_item.origin;
            s1_d_reg    <= in_item.dir;
            s1_r_reg    <= in_item.radius;
            s1_idx_reg  <= in_item.index;
            s1_last_reg <= in_item.last;

            s2_rr_reg   <= s2_rr_next;
            s2_o_reg    <= s1_o_reg;
            s2_d_reg    <= s1_d_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_last_reg <= s1_last_reg;

            s3_b_reg    <= s3_b_next;
            s3_c_reg    <= s3_c_next;
            s3_o_reg    <= s2_o_reg;
            s3_d_reg    <= s2_d_reg;
            s3_idx_reg  <= s2_idx_reg;
            s3_last_reg <= s2_last_reg;

            s4_b_reg    <= s3_b_reg;
            s4_bb_reg   <= s4_bb_next;
            s4_c4_reg   <= s4_c4_next;
            s4_o_reg    <= s3_o_reg;
            s4_d_reg    <= s3_d_reg;
            s4_idx_reg  <= s3_idx_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

endmodule
`default_nettype wire

### design/rsch_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rsch_queue
    import rsch_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t wr_data,
    input  wire logic     pop,
    output q_entry_t      rd_data,
    output q_status_t     status
);

    q_entry_t             entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rd_data      = entries_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

### design/rsch_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rsch_back
    import rsch_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_entry_t  q_data,
    input  wire q_status_t q_status,
    output logic           q_pop,
    output logic           out_valid,
    output result_t        out_data,
    input  wire logic      out_pop
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_TMIN = 3'd2;
    localparam logic [2:0] ST_PMUL = 3'd3;
    localparam logic [2:0] ST_PSUM = 3'd4;

    logic [2:0] state_reg, state_next;

    // running minimum
    logic               have_reg, have_next;
    logic signed [31:0] best_t_reg, best_t_next;
    logic [3:0]         best_idx_reg, best_idx_next;

    // current transaction
    logic                    w_last_reg, w_last_next;
    logic [3:0]              w_idx_reg, w_idx_next;
    logic signed [31:0]      w_b_reg, w_b_next;
    logic signed [2:0][31:0] w_o_reg, w_o_next;
    logic signed [2:0][17:0] w_d_reg, w_d_next;

    // square root
    logic [63:0]           rad_reg, rad_next;
    logic [31:0]           root_reg, root_next;
    logic [35:0]           rem_reg, rem_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [35:0]           rem_sh;
    logic [35:0]           trial;

    // point products
    logic signed [49:0] prod_reg [3];
    logic signed [49:0] prod_next [3];

    logic               ov_reg, ov_next;
    result_t            res_reg, res_next;
    logic signed [33:0] t_wide;
    logic signed [31:0] t_new;

    assign out_valid = ov_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        have_next     = have_reg;
        best_t_next   = best_t_reg;
        best_idx_next = best_idx_reg;
        w_last_next   = w_last_reg;
        w_idx_next    = w_idx_reg;
        w_b_next      = w_b_reg;
        w_o_next      = w_o_reg;
        w_d_next      = w_d_reg;
        rad_next      = rad_reg;
        root_next     = root_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        ov_next       = ov_reg && !out_pop;
        q_pop         = 1'b0;
        for (int i = 0; i < 3; i++)
            prod_next[i] = prod_reg[i];

        rem_sh = {rem_reg[33:0], rad_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        t_wide = -34'(w_b_reg) - $signed({2'b00, root_reg});
        t_new  = sat32(64'(t_wide >>> 1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop       = 1'b1;
                    w_last_next = q_data.last;
                    w_idx_next  = q_data.index;
                    w_b_next    = q_data.b;
                    w_o_next    = q_data.origin;
                    w_d_next    = q_data.dir;
                    rad_next    = q_data.disc;
                    root_next   = '0;
                    rem_next    = '0;
                    cnt_next    = '0;
                    if (q_data.cand)
                        state_next = ST_SQRT;
                    else if (q_data.last)
                        state_next = ST_PMUL;
                end
            end
            // one root bit per cycle
            ST_SQRT:
            begin
                rad_next = {rad_reg[61:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[30:0], 1'b0};
                end
                if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
                    state_next = ST_TMIN;
            end
            // nearer root and running minimum
            ST_TMIN:
            begin
                if (!have_reg || t_new < best_t_reg)
                begin
                    best_t_next   = t_new;
                    best_idx_next = w_idx_reg;
                    have_next     = 1'b1;
                end
                state_next = w_last_reg ? ST_PMUL : ST_IDLE;
            end
            ST_PMUL:
            begin
                for (int i = 0; i < 3; i++)
                    prod_next[i] = $signed(w_d_reg[i]) * best_t_reg;
                state_next = ST_PSUM;
            end
            ST_PSUM:
            begin
                if (!ov_reg || out_pop)
                begin
                    ov_next        = 1'b1;
                    res_next.hit   = have_reg;
                    res_next.t     = have_reg ? best_t_reg : '0;
                    res_next.index = have_reg ? best_idx_reg : '0;
                    for (int i = 0; i < 3; i++)
                        res_next.point[i] = have_reg ?
                            sat32(64'($signed(w_o_reg[i])) + 64'(prod_reg[i] >>> FRAC_BITS))
                            : '0;
                    have_next     = 1'b0;
                    best_t_next   = '0;
                    best_idx_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            have_reg     <= 1'b0;
            best_t_reg   <= '0;
            best_idx_reg <= '0;
            ov_reg       <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            have_reg     <= have_next;
            best_t_reg   <= best_t_next;
            best_idx_reg <= best_idx_next;
            ov_reg       <= ov_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_last_reg <= w_last_next;
        w_idx_reg  <= w_idx_next;
        w_b_reg    <= w_b_next;
        w_o_reg    <= w_o_next;
        w_d_reg    <= w_d_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        res_reg    <= res_next;
        for (int i = 0; i < 3; i++)
            prod_reg[i] <= prod_next[i];
    end

endmodule
`default_nettype wire
